/* hw/rtl/mips_integer_execute_unit_assert.svh */
// Assertion macros for the integer execute unit.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define MIE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MIE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mie_pkg.sv */
// Shared constants, opcodes and the stage type of the integer execute unit.
package mie_pkg;

   localparam int MEM_DEPTH = 1024;
   localparam int MEM_AW = $clog2(MEM_DEPTH);
   localparam logic [31:0] MEM_DEPTH_W = 32'(MEM_DEPTH);
   localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);

   localparam int REG_COUNT = 32;
   localparam int REG_AW = 5;
   localparam int LIMIT_W = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [31:0] PC_RESET = 32'h0000_0000;
   localparam logic [31:0] NPC_RESET = 32'h0000_0004;

   localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_AW-1:0] REG_LINK = 5'd31;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM = 6'd1;
   localparam logic [5:0] OP_J = 6'd2;
   localparam logic [5:0] OP_JAL = 6'd3;
   localparam logic [5:0] OP_BEQ = 6'd4;
   localparam logic [5:0] OP_BNE = 6'd5;
   localparam logic [5:0] OP_ADDI = 6'd8;
   localparam logic [5:0] OP_ADDIU = 6'd9;
   localparam logic [5:0] OP_SLTI = 6'd10;
   localparam logic [5:0] OP_ANDI = 6'd12;
   localparam logic [5:0] OP_ORI = 6'd13;
   localparam logic [5:0] OP_XORI = 6'd14;
   localparam logic [5:0] OP_LUI = 6'd15;
   localparam logic [5:0] OP_LB = 6'd32;
   localparam logic [5:0] OP_LW = 6'd35;
   localparam logic [5:0] OP_LBU = 6'd36;
   localparam logic [5:0] OP_SB = 6'd40;
   localparam logic [5:0] OP_SW = 6'd43;

   localparam logic [5:0] FN_SLL = 6'd0;
   localparam logic [5:0] FN_SRL = 6'd2;
   localparam logic [5:0] FN_SRA = 6'd3;
   localparam logic [5:0] FN_SLLV = 6'd4;
   localparam logic [5:0] FN_SRLV = 6'd6;
   localparam logic [5:0] FN_SRAV = 6'd7;
   localparam logic [5:0] FN_JR = 6'd8;
   localparam logic [5:0] FN_ADD = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND = 6'd36;
   localparam logic [5:0] FN_OR = 6'd37;
   localparam logic [5:0] FN_XOR = 6'd38;
   localparam logic [5:0] FN_NOR = 6'd39;
   localparam logic [5:0] FN_SLT = 6'd42;

   localparam logic [1:0] LD_WORD = 2'd0;
   localparam logic [1:0] LD_BYTE = 2'd1;
   localparam logic [1:0] LD_BYTE_U = 2'd2;

   typedef struct packed {
      logic [31:0] next_pc;
      logic reg_write;
      logic [REG_AW-1:0] reg_index;
      logic [31:0] reg_value;
      logic load;
      logic [1:0] load_kind;
      logic store;
      logic store_byte;
      logic [31:0] store_data;
      logic [MEM_AW-1:0] mem_addr;
      logic [9:0] mem_index;
      logic out_of_range;
      logic unknown_op;
   } mie_exec_type;

endpackage

/* hw/rtl/mie_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mie_exec.sv */
// Decode and execute of one instruction: ALU, branch and jump targets, memory index check.
module mie_exec (
   input logic [31:0] instr,
   input logic [31:0] pc,
   input logic [31:0] npc,
   input logic [31:0] a,
   input logic [31:0] b,
   input logic [mie_pkg::LIMIT_W-1:0] data_limit,
   output logic [31:0] new_npc,
   output mie_pkg::mie_exec_type ex
);
   import mie_pkg::*;

   logic [5:0] op;
   logic [5:0] fn;
   logic [REG_AW-1:0] rt;
   logic [REG_AW-1:0] rd;
   logic [4:0] sh;
   logic [15:0] imm;
   logic [31:0] simm;
   logic [31:0] pc4;
   logic [31:0] btarget;
   logic [31:0] jtarget;
   logic [31:0] mem_idx;
   logic [31:0] limit;
   logic oor;
   logic has_dst;
   logic [REG_AW-1:0] dst;
   logic [31:0] val;

   assign op = instr[31:26];
   assign fn = instr[5:0];
   assign rt = instr[20:16];
   assign rd = instr[15:11];
   assign sh = instr[10:6];
   assign imm = instr[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign pc4 = pc + 32'd4;
   assign btarget = pc4 + {simm[29:0], 2'b00};
   assign jtarget = {pc4[31:28], instr[25:0], 2'b00};
   assign mem_idx = a + simm;
   assign limit = (32'(data_limit) < MEM_DEPTH_W) ? 32'(data_limit) : MEM_DEPTH_W;
   assign oor = (mem_idx >= limit);

   always_comb begin
      ex = '0;
      ex.next_pc = npc;
      ex.store_data = b;
      ex.mem_addr = mem_idx[MEM_AW-1:0];
      new_npc = npc + 32'd4;
      has_dst = 1'b0;
      dst = rt;
      val = '0;
      unique case (op) inside
         OP_SPECIAL: begin
            has_dst = 1'b1;
            dst = rd;
            unique case (fn) inside
               FN_ADD, FN_ADDU: val = a + b;
               FN_SUB, FN_SUBU: val = a - b;
               FN_AND: val = a & b;
               FN_OR: val = a | b;
               FN_XOR: val = a ^ b;
               FN_NOR: val = ~(a | b);
               FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
               FN_SLLV: val = b << a[4:0];
               FN_SRLV: val = b >> a[4:0];
               FN_SRAV: val = 32'($signed(b) >>> a[4:0]);
               FN_SLL: val = b << sh;
               FN_SRL: val = b >> sh;
               FN_SRA: val = 32'($signed(b) >>> sh);
               FN_JR: begin
                  has_dst = 1'b0;
                  new_npc = a;
               end
               default: begin
                  has_dst = 1'b0;
                  ex.unknown_op = 1'b1;
               end
            endcase
         end
         OP_REGIMM: begin
            if (rt == REG_ZERO) begin
               if (a[31]) begin
                  new_npc = btarget;
               end
            end else begin
               ex.unknown_op = 1'b1;
            end
         end
         OP_J: new_npc = jtarget;
         OP_JAL: begin
            new_npc = jtarget;
            has_dst = 1'b1;
            dst = REG_LINK;
            val = pc + 32'd8;
         end
         OP_BEQ: begin
            if (a == b) begin
               new_npc = btarget;
            end
         end
         OP_BNE: begin
            if (a != b) begin
               new_npc = btarget;
            end
         end
         OP_ADDI, OP_ADDIU: begin
            has_dst = 1'b1;
            val = a + simm;
         end
         OP_SLTI: begin
            has_dst = 1'b1;
            val = {31'd0, $signed(a) < $signed(simm)};
         end
         OP_ANDI: begin
            has_dst = 1'b1;
            val = a & {16'd0, imm};
         end
         OP_ORI: begin
            has_dst = 1'b1;
            val = a | {16'd0, imm};
         end
         OP_XORI: begin
            has_dst = 1'b1;
            val = a ^ {16'd0, imm};
         end
         OP_LUI: begin
            has_dst = 1'b1;
            val = {imm, 16'd0};
         end
         OP_LB, OP_LW, OP_LBU: begin
            ex.mem_index = mem_idx[9:0];
            ex.out_of_range = oor;
            if (!oor) begin
               has_dst = 1'b1;
               ex.load = 1'b1;
               if (op == OP_LW) begin
                  ex.load_kind = LD_WORD;
               end else if (op == OP_LB) begin
                  ex.load_kind = LD_BYTE;
               end else begin
                  ex.load_kind = LD_BYTE_U;
               end
            end
         end
         OP_SB, OP_SW: begin
            ex.mem_index = mem_idx[9:0];
            ex.out_of_range = oor;
            ex.store = !oor;
            ex.store_byte = (op == OP_SB);
         end
         default: ex.unknown_op = 1'b1;
      endcase
      ex.reg_write = has_dst && (dst != REG_ZERO);
      ex.reg_index = ex.reg_write ? dst : REG_ZERO;
      ex.reg_value = ex.reg_write ? val : 32'd0;
   end

endmodule

/* hw/rtl/mips_integer_execute_unit.sv */
// Top level of the MIPS32 integer-subset execute unit.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid, req_stall   req_instr
//   rsp_     out        rsp_valid, rsp_stall   rsp_next_pc ... rsp_unknown_op
//   csr_     in         csr_valid, csr_ready   csr_data (data limit)
//
// One instruction is accepted per cycle while req_stall is low, then passes s1,
// s2 and rsp_. Register file and data memory are synchronous RAMs read a stage
// ahead of use; register and memory writes are forwarded to younger instructions.
// After reset the data memory is cleared one word per cycle, all MEM_DEPTH (1024)
// words, while req_stall stays high. A stalled result holds the whole pipeline.

`include "mips_integer_execute_unit_assert.svh"

module mips_integer_execute_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [31:0] req_instr,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic rsp_reg_write,
   output logic [mie_pkg::REG_AW-1:0] rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic rsp_mem_write,
   output logic [9:0] rsp_mem_index,
   output logic [31:0] rsp_mem_value,
   output logic rsp_out_of_range,
   output logic rsp_unknown_op,
   input logic csr_valid,
   output logic csr_ready,
   input logic [mie_pkg::LIMIT_W-1:0] csr_data
);
   import mie_pkg::*;

   logic adv;
   logic accept;

   logic clearing_ff;
   logic [MEM_AW-1:0] clr_addr_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic s1_valid_ff;
   logic [31:0] s1_instr_ff;
   logic s2_valid_ff;
   mie_exec_type s2_ff;
   mie_exec_type ex_in;
   logic [31:0] pc_ff;
   logic [31:0] npc_ff;
   logic [31:0] npc_in;

   logic [REG_COUNT-1:0] rf_valid_ff;
   logic wb_valid_ff;
   logic [REG_AW-1:0] wb_index_ff;
   logic [31:0] wb_value_ff;
   logic mwb_valid_ff;
   logic [MEM_AW-1:0] mwb_addr_ff;
   logic [31:0] mwb_data_ff;

   logic [REG_AW-1:0] rs_addr;
   logic [REG_AW-1:0] rt_addr;
   logic [REG_AW-1:0] s1_rs;
   logic [REG_AW-1:0] s1_rt;
   logic [31:0] rf_a_q;
   logic [31:0] rf_b_q;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic rf_we;
   logic [REG_AW-1:0] rf_waddr;

   logic dm_we;
   logic [MEM_AW-1:0] dm_waddr;
   logic [31:0] dm_wdata;
   logic [MEM_AW-1:0] dm_raddr;
   logic [31:0] dm_q;
   logic [31:0] mem_word;
   logic [31:0] load_val;
   logic [31:0] s2_value;
   logic [31:0] s2_store_data;
   logic s2_write;
   logic s2_store;

   logic rsp_valid_ff;
   logic [31:0] rsp_next_pc_ff;
   logic rsp_reg_write_ff;
   logic [REG_AW-1:0] rsp_reg_index_ff;
   logic [31:0] rsp_reg_value_ff;
   logic rsp_mem_write_ff;
   logic [9:0] rsp_mem_index_ff;
   logic [31:0] rsp_mem_value_ff;
   logic rsp_out_of_range_ff;
   logic rsp_unknown_op_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clearing_ff || !adv;
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_rs = s1_instr_ff[25:21];
   assign s1_rt = s1_instr_ff[20:16];
   assign rs_addr = adv ? req_instr[25:21] : s1_rs;
   assign rt_addr = adv ? req_instr[20:16] : s1_rt;

   assign s2_write = s2_valid_ff && s2_ff.reg_write;
   assign s2_store = s2_valid_ff && s2_ff.store;
   assign rf_we = s2_write && adv;
   assign rf_waddr = s2_ff.reg_index;

   mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
      .clock(clock),
      .wr_en(rf_we),
      .wr_addr(rf_waddr),
      .wr_data(s2_value),
      .rd_addr(rs_addr),
      .rd_data(rf_a_q)
   );

   mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
      .clock(clock),
      .wr_en(rf_we),
      .wr_addr(rf_waddr),
      .wr_data(s2_value),
      .rd_addr(rt_addr),
      .rd_data(rf_b_q)
   );

   always_comb begin
      if (s2_write && s2_ff.reg_index == s1_rs) begin
         op_a = s2_value;
      end else if (wb_valid_ff && wb_index_ff == s1_rs) begin
         op_a = wb_value_ff;
      end else if (rf_valid_ff[s1_rs]) begin
         op_a = rf_a_q;
      end else begin
         op_a = 32'd0;
      end
      if (s2_write && s2_ff.reg_index == s1_rt) begin
         op_b = s2_value;
      end else if (wb_valid_ff && wb_index_ff == s1_rt) begin
         op_b = wb_value_ff;
      end else if (rf_valid_ff[s1_rt]) begin
         op_b = rf_b_q;
      end else begin
         op_b = 32'd0;
      end
   end

   mie_exec u_exec (
      .instr(s1_instr_ff),
      .pc(pc_ff),
      .npc(npc_ff),
      .a(op_a),
      .b(op_b),
      .data_limit(limit_ff),
      .new_npc(npc_in),
      .ex(ex_in)
   );

   assign dm_raddr = adv ? ex_in.mem_addr : s2_ff.mem_addr;
   assign dm_we = clearing_ff || (s2_store && adv);
   assign dm_waddr = clearing_ff ? clr_addr_ff : s2_ff.mem_addr;
   assign dm_wdata = clearing_ff ? 32'd0 : s2_store_data;

   mie_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock(clock),
      .wr_en(dm_we),
      .wr_addr(dm_waddr),
      .wr_data(dm_wdata),
      .rd_addr(dm_raddr),
      .rd_data(dm_q)
   );

   assign mem_word = (mwb_valid_ff && mwb_addr_ff == s2_ff.mem_addr) ? mwb_data_ff : dm_q;

   always_comb begin
      case (s2_ff.load_kind)
         LD_WORD: load_val = mem_word;
         LD_BYTE: load_val = {{24{mem_word[7]}}, mem_word[7:0]};
         LD_BYTE_U: load_val = {24'd0, mem_word[7:0]};
         default: load_val = mem_word;
      endcase
   end

   assign s2_value = !s2_ff.reg_write ? 32'd0 : (s2_ff.load ? load_val : s2_ff.reg_value);
   assign s2_store_data = s2_ff.store_byte ? {mem_word[31:8], s2_ff.store_data[7:0]}
                                           : s2_ff.store_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         limit_ff <= LIMIT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff <= PC_RESET;
         npc_ff <= NPC_RESET;
         rf_valid_ff <= '0;
         wb_valid_ff <= 1'b0;
         mwb_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == MEM_LAST) begin
               clearing_ff <= 1'b0;
            end
         end
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
            if (s1_valid_ff) begin
               pc_ff <= npc_ff;
               npc_ff <= npc_in;
            end
            if (s2_write) begin
               rf_valid_ff[s2_ff.reg_index] <= 1'b1;
               wb_valid_ff <= 1'b1;
            end
            if (s2_store) begin
               mwb_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr;
      end
      if (adv) begin
         s2_ff <= ex_in;
         if (s2_write) begin
            wb_index_ff <= s2_ff.reg_index;
            wb_value_ff <= s2_value;
         end
         if (s2_store) begin
            mwb_addr_ff <= s2_ff.mem_addr;
            mwb_data_ff <= s2_store_data;
         end
         rsp_next_pc_ff <= s2_ff.next_pc;
         rsp_reg_write_ff <= s2_ff.reg_write;
         rsp_reg_index_ff <= s2_ff.reg_index;
         rsp_reg_value_ff <= s2_value;
         rsp_mem_write_ff <= s2_ff.store;
         rsp_mem_index_ff <= s2_ff.mem_index;
         rsp_mem_value_ff <= s2_ff.store ? s2_store_data : 32'd0;
         rsp_out_of_range_ff <= s2_ff.out_of_range;
         rsp_unknown_op_ff <= s2_ff.unknown_op;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_pc = rsp_next_pc_ff;
   assign rsp_reg_write = rsp_reg_write_ff;
   assign rsp_reg_index = rsp_reg_index_ff;
   assign rsp_reg_value = rsp_reg_value_ff;
   assign rsp_mem_write = rsp_mem_write_ff;
   assign rsp_mem_index = rsp_mem_index_ff;
   assign rsp_mem_value = rsp_mem_value_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;
   assign rsp_unknown_op = rsp_unknown_op_ff;

   `MIE_ASSERT_IMPLIES(a_no_work_while_clearing, clearing_ff, !s1_valid_ff && !s2_valid_ff, "Instruction in flight during memory clear.")
   `MIE_ASSERT_ALWAYS(a_zero_reg_never_written, !(rf_we && rf_waddr == REG_ZERO), "Register zero written.")
   `MIE_ASSERT_IMPLIES(a_range_fault_no_write, rsp_valid_ff && rsp_out_of_range_ff, !rsp_mem_write_ff && !rsp_reg_write_ff, "Out-of-range access wrote state.")
   `MIE_ASSERT_NEXT(a_pc_takes_delay_slot, s1_valid_ff && adv, pc_ff == $past(npc_ff), "Program counter did not advance to the delay slot.")

endmodule
